@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the analog key RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AKRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AKRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/akrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akrt_pkg
// Types and constants of the analog key rapid trigger block.
// ----------------------------------------------------------------------------
package akrt_pkg;

  localparam int ADC_W   = 12;
  localparam int FRAC_W  = 8;
  localparam int ACC_W   = ADC_W + FRAC_W;
  localparam int PM_W    = 10;
  localparam int KEY_W   = 6;
  localparam int SHIFT_W = 4;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  // Serial divider: per-mille numerator is at most 4095 * 1000.
  localparam int NUM_W = 22;
  localparam int DEN_W = ADC_W;
  localparam int CNT_W = 5;

  localparam logic [PM_W-1:0] PM_FULL = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASED_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_DELTA        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_DELTA        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAPID_ENABLE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SHIFT   = 3'd7;

  typedef struct packed {
    logic [ADC_W-1:0]   released_level;
    logic [ADC_W-1:0]   pressed_level;
    logic [PM_W-1:0]    press_threshold;
    logic [PM_W-1:0]    release_threshold;
    logic [PM_W-1:0]    rise_delta;
    logic [PM_W-1:0]    fall_delta;
    logic               rapid_enable;
    logic [SHIFT_W-1:0] smoothing_shift;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    released_level:    12'd1000,
    pressed_level:     12'd3000,
    press_threshold:   10'd500,
    release_threshold: 10'd350,
    rise_delta:        10'd80,
    fall_delta:        10'd80,
    rapid_enable:      1'b1,
    smoothing_shift:   4'd2
  };

  // Per-key record kept in the key memory.
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             down;
    logic             armed;
    logic [PM_W-1:0]  peak;
    logic [PM_W-1:0]  valley;
  } key_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FILT,
    S_PREP,
    S_DIV,
    S_DECIDE
  } state_t;

endpackage

@@ hdl/analog_key_rapid_trigger.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_key_rapid_trigger
// Per-key filter, travel position and hysteresis / rapid trigger state.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one key index and one
//   raw sample per transaction. The output channel (out_valid / out_ready)
//   returns exactly one result per input transaction, in order.
//   A trivially zero position skips the division, a key index out of range
//   goes straight to the decision, and any other item waits for the
//   bit-serial per-mille divider. One item is in work at a time, so a new
//   item is taken only once the last one has left the decision state.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the following item stops before its
//   memory write and holds until the output register frees.
//   Configuration is written through cfg_we / cfg_index / cfg_data at any
//   edge and must only change while the block is idle.
//   Reset restores register defaults and marks every key unseeded; an
//   unseeded key reads as all-zero state, so no clearing pass is needed.
//   A key index at or above NUM_KEYS returns its index with zero fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module analog_key_rapid_trigger #(
  parameter int NUM_KEYS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [akrt_pkg::KEY_W-1:0]    key_index,
  input  logic [akrt_pkg::ADC_W-1:0]    adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [akrt_pkg::KEY_W-1:0]    key_out,
  output logic                          is_down,
  output logic                          armed,
  output logic                          changed,
  output logic [akrt_pkg::ADC_W-1:0]    smoothed_adc,
  output logic [akrt_pkg::PM_W-1:0]     position,
  output logic [akrt_pkg::PM_W-1:0]     peak_position,
  input  logic                          cfg_we,
  input  logic [akrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [akrt_pkg::CFG_W-1:0]    cfg_data
);
  import akrt_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  state_t state, state_next;
  cfg_t   cfg;

  key_entry_t mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] seeded;

  logic [KEY_W-1:0]  key_q;
  logic [ADC_W-1:0]  sample_q;
  logic              oor;
  logic [8:0]        key_ext;
  logic [KW-1:0]     addr;
  key_entry_t        rd_entry;
  logic              ent_valid;
  key_entry_t        ent;
  logic [ACC_W-1:0]  acc_q;
  logic [ADC_W-1:0]  smooth_q;
  logic [PM_W-1:0]   pos_q;

  logic [ACC_W-1:0]  target;
  logic [ACC_W-1:0]  acc_new;
  logic [ACC_W:0]    rnd;
  logic [ADC_W-1:0]  smooth_new;
  logic signed [ADC_W+1:0] diff;
  logic signed [ADC_W:0]   span;
  logic [ADC_W+1:0]  mag_d;
  logic [ADC_W:0]    mag_s;
  logic              trivial;
  logic [NUM_W-1:0]  div_num;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_q;

  key_entry_t        upd;
  logic              upd_changed;
  logic              out_free;
  logic              accept;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign key_ext  = {3'b000, key_q};
  assign addr     = key_ext[KW-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELEASED_LEVEL:    cfg.released_level    <= cfg_data;
        REG_PRESSED_LEVEL:     cfg.pressed_level     <= cfg_data;
        REG_PRESS_THRESHOLD:   cfg.press_threshold   <= cfg_data[PM_W-1:0];
        REG_RELEASE_THRESHOLD: cfg.release_threshold <= cfg_data[PM_W-1:0];
        REG_RISE_DELTA:        cfg.rise_delta        <= cfg_data[PM_W-1:0];
        REG_FALL_DELTA:        cfg.fall_delta        <= cfg_data[PM_W-1:0];
        REG_RAPID_ENABLE:      cfg.rapid_enable      <= cfg_data[0];
        REG_SMOOTHING_SHIFT:   cfg.smoothing_shift   <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ({3'b000, key_index} >= 9'(NUM_KEYS)) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ:  state_next = S_FILT;
      S_FILT:  state_next = S_PREP;
      S_PREP: begin
        if (trivial) begin
          state_next = S_DECIDE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Unseeded keys read as the all-zero reset record.
  assign ent = ent_valid ? rd_entry : '0;

  always_comb begin
    target = {sample_q, {FRAC_W{1'b0}}};
    if (!ent_valid) begin
      acc_new = target;
    end else if (target >= ent.acc) begin
      acc_new = ent.acc + ((target - ent.acc) >> cfg.smoothing_shift);
    end else begin
      acc_new = ent.acc - ((ent.acc - target) >> cfg.smoothing_shift);
    end
    rnd = {1'b0, acc_new} + (ACC_W+1)'(1 << (FRAC_W - 1));
    if (rnd[ACC_W]) begin
      smooth_new = '1;
    end else begin
      smooth_new = rnd[ACC_W-1:FRAC_W];
    end
  end

  always_comb begin
    diff    = $signed({2'b00, smooth_q}) - $signed({2'b00, cfg.released_level});
    span    = $signed({1'b0, cfg.pressed_level}) - $signed({1'b0, cfg.released_level});
    mag_d   = diff[ADC_W+1] ? (ADC_W+2)'(-diff) : diff;
    mag_s   = span[ADC_W] ? (ADC_W+1)'(-span) : span;
    // Opposite signs give a quotient at or below zero, which clamps to zero.
    trivial = (span == '0) || (diff == '0) || (diff[ADC_W+1] ^ span[ADC_W]);
    div_num = NUM_W'(mag_d[ADC_W-1:0]) * NUM_W'(PM_FULL);
  end

  akrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (mag_s[DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_q)
  );

  akrt_decide u_decide (
    .ent     (ent),
    .pos     (pos_q),
    .cfg     (cfg),
    .upd     (upd),
    .changed (upd_changed)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q    <= key_index;
      sample_q <= adc_sample;
      oor      <= ({3'b000, key_index} >= 9'(NUM_KEYS));
    end
    if (state == S_FILT) begin
      acc_q    <= acc_new;
      smooth_q <= smooth_new;
    end
    if ((state == S_PREP) && trivial) begin
      pos_q <= '0;
    end else if ((state == S_DIV) && div_done) begin
      pos_q <= (div_q > NUM_W'(PM_FULL)) ? PM_FULL : div_q[PM_W-1:0];
    end
  end

  // Key memory with registered read.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_entry <= mem[addr];
    end
    if ((state == S_DECIDE) && out_free && !oor) begin
      mem[addr] <= '{acc: acc_q, down: upd.down, armed: upd.armed,
                     peak: upd.peak, valley: upd.valley};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= '0;
    end else if ((state == S_DECIDE) && out_free && !oor) begin
      seeded[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      ent_valid <= seeded[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DECIDE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && out_free) begin
      key_out <= key_q;
      if (oor) begin
        is_down       <= 1'b0;
        armed         <= 1'b0;
        changed       <= 1'b0;
        smoothed_adc  <= '0;
        position      <= '0;
        peak_position <= '0;
      end else begin
        is_down       <= upd.down;
        armed         <= upd.armed;
        changed       <= upd_changed;
        smoothed_adc  <= smooth_q;
        position      <= pos_q;
        peak_position <= upd.peak;
      end
    end
  end

  `AKRT_ASSERT_NXT(a_div_to_decide, (state == S_DIV) && div_done, state == S_DECIDE)
  `AKRT_ASSERT_NXT(a_accept_read, accept && ({3'b000, key_index} < 9'(NUM_KEYS)), state == S_READ)
  `AKRT_ASSERT_IMP(a_result_from_decide, $rose(out_valid), $past(state) == S_DECIDE)
  `AKRT_ASSERT_IMP(a_div_only_in_div, div_done, state == S_DIV)

endmodule

@@ hdl/akrt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akrt_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module akrt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [akrt_pkg::NUM_W-1:0] num,
  input  logic [akrt_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [akrt_pkg::NUM_W-1:0] quot
);
  import akrt_pkg::*;

  logic [NUM_W-1:0] sr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // The numerator leaves the top of the shift register while quotient
  // bits enter at the bottom.
  always_comb begin
    trial = {rem, sr[NUM_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      sr <= {sr[NUM_W-2:0], qbit};
      if (qbit) begin
        rem <= DEN_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

  assign quot = sr;

endmodule

@@ hdl/akrt_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akrt_decide
// Hysteresis and rapid trigger decision for one key sample.
// ----------------------------------------------------------------------------
module akrt_decide (
  input  akrt_pkg::key_entry_t        ent,
  input  logic [akrt_pkg::PM_W-1:0]   pos,
  input  akrt_pkg::cfg_t              cfg,
  output akrt_pkg::key_entry_t        upd,
  output logic                        changed
);
  import akrt_pkg::*;

  logic [PM_W-1:0] valley_m;
  logic [PM_W-1:0] peak_m;
  logic [PM_W:0]   rise_sum;
  logic [PM_W:0]   fall_sum;

  always_comb begin
    valley_m = (pos < ent.valley) ? pos : ent.valley;
    peak_m   = (pos > ent.peak) ? pos : ent.peak;
    rise_sum = {1'b0, valley_m} + {1'b0, cfg.rise_delta};
    fall_sum = {1'b0, pos} + {1'b0, cfg.fall_delta};
    upd      = ent;
    if (!ent.down) begin
      upd.valley = valley_m;
      if ((cfg.rapid_enable && ent.armed && ({1'b0, pos} >= rise_sum)) ||
          (pos >= cfg.press_threshold)) begin
        upd.down   = 1'b1;
        upd.armed  = 1'b0;
        upd.peak   = pos;
        upd.valley = pos;
      end
    end else begin
      upd.peak = peak_m;
      if (cfg.rapid_enable && (fall_sum <= {1'b0, peak_m})) begin
        // A rapid release arms the key for a rapid press.
        upd.down   = 1'b0;
        upd.armed  = 1'b1;
        upd.peak   = pos;
        upd.valley = pos;
      end else if (pos <= cfg.release_threshold) begin
        upd.down   = 1'b0;
        upd.armed  = 1'b0;
        upd.peak   = pos;
        upd.valley = pos;
      end
    end
    changed = (upd.down != ent.down);
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the analog key block against a built-in predictor of the filter,
// per-mille position and hysteresis / rapid trigger rules, with random
// handshake idling, directed corner items and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import akrt_pkg::*;

  localparam int NKEYS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ADC_W-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             down;
    logic             arm;
    logic             chg;
    logic [ADC_W-1:0] smooth;
    logic [PM_W-1:0]  pos;
    logic [PM_W-1:0]  peak;
  } key_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KEY_W-1:0] key_index = '0;
  logic [ADC_W-1:0] adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] key_out;
  logic is_down, armed, changed;
  logic [ADC_W-1:0] smoothed_adc;
  logic [PM_W-1:0] position, peak_position;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  analog_key_rapid_trigger dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  cfg_t cfg;
  logic [ACC_W-1:0] m_acc [NKEYS];
  bit m_seeded [NKEYS];
  bit m_down [NKEYS];
  bit m_armed [NKEYS];
  logic [PM_W-1:0] m_peak [NKEYS];
  logic [PM_W-1:0] m_valley [NKEYS];

  sample_t pending_samples[$];
  key_report_t expected_reports[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic int travel_pm(int value);
    int span, pos;
    span = int'(cfg.pressed_level) - int'(cfg.released_level);
    if (span == 0) return 0;
    pos = ((value - int'(cfg.released_level)) * 1000) / span;
    if (pos < 0) return 0;
    if (pos > 1000) return 1000;
    return pos;
  endfunction

  function automatic key_report_t predict_key(sample_t s);
    key_report_t r;
    int k, target, acc, smooth, pos;
    bit was_down;
    r = '0;
    r.key = s.key;
    k = s.key;
    target = int'(s.sample) << FRAC_W;
    acc = m_acc[k];
    if (!m_seeded[k]) begin
      acc = target;
      m_seeded[k] = 1'b1;
    end else if (target >= acc) begin
      acc = acc + ((target - acc) >>> cfg.smoothing_shift);
    end else begin
      acc = acc - ((acc - target) >>> cfg.smoothing_shift);
    end
    m_acc[k] = ACC_W'(acc);
    smooth = (acc + 128) >>> FRAC_W;
    if (smooth > 4095) smooth = 4095;
    pos = travel_pm(smooth);
    was_down = m_down[k];
    if (!was_down) begin
      if (pos < m_valley[k]) m_valley[k] = PM_W'(pos);
      if (cfg.rapid_enable && m_armed[k] &&
          pos >= int'(m_valley[k]) + int'(cfg.rise_delta)) begin
        m_down[k] = 1'b1; m_armed[k] = 1'b0;
        m_peak[k] = PM_W'(pos); m_valley[k] = PM_W'(pos);
      end else if (pos >= cfg.press_threshold) begin
        m_down[k] = 1'b1; m_armed[k] = 1'b0;
        m_peak[k] = PM_W'(pos); m_valley[k] = PM_W'(pos);
      end
    end else begin
      if (pos > m_peak[k]) m_peak[k] = PM_W'(pos);
      if (cfg.rapid_enable && pos + int'(cfg.fall_delta) <= int'(m_peak[k])) begin
        m_down[k] = 1'b0; m_armed[k] = 1'b1;
        m_peak[k] = PM_W'(pos); m_valley[k] = PM_W'(pos);
      end else if (pos <= cfg.release_threshold) begin
        m_down[k] = 1'b0; m_armed[k] = 1'b0;
        m_peak[k] = PM_W'(pos); m_valley[k] = PM_W'(pos);
      end
    end
    r.down = m_down[k];
    r.arm = m_armed[k];
    r.chg = (m_down[k] != was_down);
    r.smooth = ADC_W'(smooth);
    r.pos = PM_W'(pos);
    r.peak = m_peak[k];
    return r;
  endfunction

  // Driver: the item on the bus stays at the head of the queue until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_reports.push_back(predict_key(sample_t'({key_index, adc_sample})));
        void'(pending_samples.pop_front());
      end
      if (pending_samples.size() > 0) begin
        if ($urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {key_index, adc_sample} <= pending_samples[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    key_report_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {key_out, is_down, armed, changed, smoothed_adc, position, peak_position};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result for key %0d", key_out);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch key %0d: expected %p, got %p", want.key, want, got);
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Each write ends with the enable low, so that the enable drops between writes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RELEASED_LEVEL:    cfg.released_level = ADC_W'(value);
      REG_PRESSED_LEVEL:     cfg.pressed_level = ADC_W'(value);
      REG_PRESS_THRESHOLD:   cfg.press_threshold = PM_W'(value);
      REG_RELEASE_THRESHOLD: cfg.release_threshold = PM_W'(value);
      REG_RISE_DELTA:        cfg.rise_delta = PM_W'(value);
      REG_FALL_DELTA:        cfg.fall_delta = PM_W'(value);
      REG_RAPID_ENABLE:      cfg.rapid_enable = value[0];
      default:               cfg.smoothing_shift = SHIFT_W'(value);
    endcase
    @(posedge clk);
  endtask

  task automatic add(int k, int s);
    pending_samples.push_back(sample_t'({k[KEY_W-1:0], s[ADC_W-1:0]}));
  endtask

  // A jittered stroke of random depth on one key, with occasional random items on any key.
  task automatic add_stroke(int n);
    int k, lvl, dir;
    k = $urandom_range(NKEYS - 1);
    lvl = $urandom_range(4095);
    for (int i = 0; i < n; i++) begin
      dir = $urandom_range(2);
      lvl = lvl + (dir == 0 ? -int'($urandom_range(600)) : int'($urandom_range(600)));
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      if ($urandom_range(9) == 0) add($urandom_range(NKEYS - 1), $urandom);
      else add(k, lvl);
    end
  endtask

  task automatic random_phase(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(4) == 0) begin
        add($urandom, $urandom);
        cnt++;
      end else begin
        add_stroke(8);
        cnt += 8;
      end
    end
  endtask

  initial begin
    cfg = CFG_RESET;
    for (int k = 0; k < NKEYS; k++) begin
      m_acc[k] = '0; m_seeded[k] = 0; m_down[k] = 0; m_armed[k] = 0;
      m_peak[k] = '0; m_valley[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, press, rapid release and rapid re-press.
    send_idle_pct = 0; recv_idle_pct = 0;
    add(0, 0); add(63, 4095); add(1, 4095); add(1, 4095); add(1, 2500);
    add(1, 1500); add(1, 1500); add(1, 3000); add(1, 3000); add(1, 0);
    add(2, 2000); add(2, 3400); add(2, 1000); add(1, 12'haaa); add(1, 12'h555);
    drain();

    // Zero span, no smoothing.
    write_reg(REG_PRESSED_LEVEL, 1000);
    write_reg(REG_SMOOTHING_SHIFT, 0);
    add(3, 1000); add(3, 4095); add(3, 0);
    drain();

    // Inverted calibration, slow filter, extreme thresholds, rapid off.
    write_reg(REG_RELEASED_LEVEL, 4095);
    write_reg(REG_PRESSED_LEVEL, 0);
    write_reg(REG_SMOOTHING_SHIFT, 15);
    write_reg(REG_PRESS_THRESHOLD, 1000);
    write_reg(REG_RELEASE_THRESHOLD, 0);
    write_reg(REG_RAPID_ENABLE, 0);
    add(4, 0); add(4, 4095); add(4, 0); add(5, 4095); add(5, 0); add(5, 4095);
    drain();

    // Random with the sender idling less than the receiver.
    write_reg(REG_RELEASED_LEVEL, 500);
    write_reg(REG_PRESSED_LEVEL, 3600);
    write_reg(REG_PRESS_THRESHOLD, 600);
    write_reg(REG_RELEASE_THRESHOLD, 400);
    write_reg(REG_RISE_DELTA, 0);
    write_reg(REG_FALL_DELTA, 1000);
    write_reg(REG_RAPID_ENABLE, 1);
    write_reg(REG_SMOOTHING_SHIFT, 8);
    send_idle_pct = 28; recv_idle_pct = 72;
    random_phase(120);
    recv_hold = 400;
    drain();

    // Random with the receiver idling less, default-like levels.
    write_reg(REG_RELEASED_LEVEL, 1000);
    write_reg(REG_PRESSED_LEVEL, 3000);
    write_reg(REG_PRESS_THRESHOLD, 0);
    write_reg(REG_RELEASE_THRESHOLD, 1000);
    write_reg(REG_RISE_DELTA, 1000);
    write_reg(REG_FALL_DELTA, 0);
    write_reg(REG_SMOOTHING_SHIFT, 1);
    send_idle_pct = 72; recv_idle_pct = 28;
    random_phase(120);
    drain();

    // No idling, ordinary rapid trigger settings.
    write_reg(REG_PRESS_THRESHOLD, 500);
    write_reg(REG_RELEASE_THRESHOLD, 350);
    write_reg(REG_RISE_DELTA, 60);
    write_reg(REG_FALL_DELTA, 60);
    write_reg(REG_SMOOTHING_SHIFT, 2);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(280);
    drain();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
